[hdl/pgf_pkg.sv]
// pgf_pkg: shared types and constants of the packed gray framebuffer
// no dependencies; imported by the controller, the datapath and the top level

package pgf_pkg;

    // default geometry
    localparam int ROWS_DEF          = 128;
    localparam int ROW_STRIDE_DEF    = 258;
    localparam int PACKED_STRIDE_DEF = 86;

    // field widths fixed by the interface
    localparam int X_W     = 9;
    localparam int Y_W     = 7;
    localparam int SHADE_W = 8;
    localparam int WIDX_W  = 14;
    localparam int WORD_W  = 32;

    // divide by three: x / 3 == (x * 683) >> 11 for any 9-bit x
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_W     = 19;
    localparam int QUOT_W     = 8;

    // packed-format byte masks
    localparam logic [7:0] MASK_LANE0 = 8'h3F;
    localparam logic [7:0] MASK_LANE1 = 8'hE7;
    localparam logic [7:0] MASK_LANE2 = 8'hFC;
    localparam logic [7:0] FILL_BITS  = 8'h24;

    // pixel format codes
    localparam logic FMT_PACKED = 1'b0;
    localparam logic FMT_LINEAR = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
        logic clear_start;
        logic clear_step;
    } pgf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } pgf_status_t;

endpackage

[hdl/pgf_ram.sv]
// pgf_ram: generic single-port ram with registered read data
// no dependencies

module pgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pgf_ctrl.sv]
// pgf_ctrl: sequencing state machine of the packed gray framebuffer
// depends on pgf_pkg (state, action, command and status types)

module pgf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pgf_pkg::action_t     action,
    input  pgf_pkg::pgf_status_t status,
    output pgf_pkg::pgf_cmd_t    cmd,
    output logic                 busy
);

    import pgf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // items are taken while idle and in the last cycle of a write or read
    assign accept = start && ((state_reg == ST_IDLE) || (state_reg == ST_FINISH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_FINISH;
            end
            ST_IDLE, ST_FINISH:
            begin
                state_next = ST_IDLE;
                if (accept)
                begin
                    unique case (action) inside
                        ACT_WRITE, ACT_READ: state_next = ST_ISSUE;
                        ACT_CLEAR:           state_next = ST_CLEAR;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load        = accept;
        cmd.issue       = (state_reg == ST_ISSUE);
        cmd.finish      = (state_reg == ST_FINISH);
        cmd.clear_start = accept && (action == ACT_CLEAR);
        cmd.clear_step  = (state_reg == ST_CLEAR);
        busy            = (state_reg == ST_CLEAR) || (state_reg == ST_ISSUE);
    end

endmodule

[hdl/pgf_datapath.sv]
// pgf_datapath: address arithmetic, pixel packing and the word-wide store
// depends on pgf_pkg and pgf_ram

module pgf_datapath #(
    parameter int ROWS          = pgf_pkg::ROWS_DEF,
    parameter int ROW_STRIDE    = pgf_pkg::ROW_STRIDE_DEF,
    parameter int PACKED_STRIDE = pgf_pkg::PACKED_STRIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pgf_pkg::pgf_cmd_t             cmd,
    output pgf_pkg::pgf_status_t          status,
    input  logic                          cfg_we,
    input  logic                          cfg_data,
    input  pgf_pkg::action_t              action,
    input  logic [pgf_pkg::X_W-1:0]       x_pos,
    input  logic [pgf_pkg::Y_W-1:0]       y_pos,
    input  logic [pgf_pkg::SHADE_W-1:0]   shade,
    input  logic [pgf_pkg::WIDX_W-1:0]    word_index,
    output logic                          read_valid,
    output logic [pgf_pkg::WORD_W-1:0]    read_word
);

    import pgf_pkg::*;

    localparam int STORE_BYTES = ROW_STRIDE * ROWS;
    localparam int WORDS       = (STORE_BYTES + 3) / 4;
    localparam int WORD_AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int STRIDE_MAX  = (ROW_STRIDE > PACKED_STRIDE) ? ROW_STRIDE : PACKED_STRIDE;
    localparam int STRIDE_W    = $clog2(STRIDE_MAX + 1);
    localparam int ROWOFF_W    = Y_W + STRIDE_W;
    localparam int SUM_W       = ((ROWOFF_W > X_W) ? ROWOFF_W : X_W) + 1;

    // configuration
    logic                fmt_reg;

    // item registers, loaded on accept
    action_t             op_reg;
    logic                op_fmt_reg;
    logic [X_W-1:0]      col_reg;
    logic [1:0]          rem_reg;
    logic [ROWOFF_W-1:0] rowoff_reg;
    logic                ok_reg;
    logic [SHADE_W-1:0]  shade_reg;
    logic [WORD_AW-1:0]  widx_reg;
    logic                rd_ok_reg;

    // registers loaded in the issue cycle
    logic [WORD_AW-1:0]  addr_reg;
    logic [1:0]          lane_reg;
    logic                wr_ok_reg;

    // clear sweep
    logic [WORD_AW-1:0]  clr_cnt_reg;
    logic [WORD_AW-1:0]  clr_cnt_next;

    // accept-cycle arithmetic
    logic [DIV3_W-1:0]   div3_prod;
    logic [QUOT_W-1:0]   quot3;
    logic [X_W-1:0]      rem_full;
    logic [X_W-1:0]      col_next;
    logic [STRIDE_W-1:0] stride_sel;
    logic [ROWOFF_W-1:0] rowoff_next;
    logic                ok_next;
    logic                rd_ok_next;

    // issue-cycle arithmetic
    logic [SUM_W-1:0]    byte_addr;
    logic [WORD_AW-1:0]  byte_word;
    logic                in_store;

    // finish-cycle merge
    logic [7:0]          old_byte;
    logic [7:0]          packed_byte;
    logic [7:0]          new_byte;
    logic [WORD_W-1:0]   merged_word;

    // memory port
    logic                ram_we;
    logic [WORD_AW-1:0]  ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_LINEAR;
        end
        else if (cfg_we)
        begin
            fmt_reg <= cfg_data;
        end
    end

    always_comb
    begin
        div3_prod   = DIV3_W'(x_pos) * DIV3_W'(DIV3_MUL);
        quot3       = div3_prod[DIV3_SHIFT +: QUOT_W];
        rem_full    = x_pos - X_W'(X_W'(quot3) * X_W'(3));
        col_next    = (fmt_reg == FMT_LINEAR) ? x_pos : X_W'(quot3);
        stride_sel  = (fmt_reg == FMT_LINEAR) ? STRIDE_W'(ROW_STRIDE)
                                               : STRIDE_W'(PACKED_STRIDE);
        rowoff_next = ROWOFF_W'(y_pos) * ROWOFF_W'(stride_sel);
        ok_next     = (32'(x_pos) < 32'(ROW_STRIDE)) && (32'(y_pos) < 32'(ROWS))
                      && ((fmt_reg == FMT_LINEAR) || (32'(quot3) < 32'(PACKED_STRIDE)));
        rd_ok_next  = 32'(word_index) < 32'(WORDS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= ACT_NONE;
        end
        else if (cmd.load)
        begin
            op_reg <= action;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_fmt_reg <= fmt_reg;
            col_reg    <= col_next;
            rem_reg    <= rem_full[1:0];
            rowoff_reg <= rowoff_next;
            ok_reg     <= ok_next;
            shade_reg  <= shade;
            widx_reg   <= WORD_AW'(word_index);
            rd_ok_reg  <= rd_ok_next;
        end
    end

    always_comb
    begin
        byte_addr = SUM_W'(col_reg) + SUM_W'(rowoff_reg);
        byte_word = WORD_AW'(byte_addr >> 2);
        in_store  = 32'(byte_addr) < 32'(STORE_BYTES);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            addr_reg  <= ram_addr;
            lane_reg  <= byte_addr[1:0];
            wr_ok_reg <= ok_reg && in_store;
        end
    end

    always_comb
    begin
        old_byte = ram_rdata[8*lane_reg +: 8];
        case (rem_reg)
            2'd0:    packed_byte = (old_byte & MASK_LANE0) | {shade_reg[1:0], 6'b0};
            2'd1:    packed_byte = (old_byte & MASK_LANE1) | {3'b0, shade_reg[1:0], 3'b0};
            default: packed_byte = (old_byte & MASK_LANE2) | {6'b0, shade_reg[1:0]};
        endcase
        new_byte = (op_fmt_reg == FMT_LINEAR) ? shade_reg : (packed_byte | FILL_BITS);
        for (int i = 0; i < 4; i++)
        begin
            merged_word[8*i +: 8] = (lane_reg == 2'(i)) ? new_byte : ram_rdata[8*i +: 8];
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_start)
        begin
            clr_cnt_next = '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign status.clear_last = (clr_cnt_reg == WORD_AW'(WORDS - 1));

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_addr = clr_cnt_reg;
        end
        else if (cmd.issue)
        begin
            ram_addr = (op_reg == ACT_READ) ? widx_reg : byte_word;
        end
        else
        begin
            ram_addr = addr_reg;
        end
        ram_we    = cmd.clear_step || (cmd.finish && (op_reg == ACT_WRITE) && wr_ok_reg);
        ram_wdata = cmd.clear_step ? '0 : merged_word;
    end

    pgf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign read_valid = cmd.finish && (op_reg == ACT_READ);
    assign read_word  = rd_ok_reg ? ram_rdata : '0;

endmodule

[hdl/packed_gray_framebuffer.sv]
// packed_gray_framebuffer: top level of the byte framebuffer for a grayscale panel
// depends on pgf_pkg, pgf_ctrl, pgf_datapath (which holds pgf_ram)

// A command is taken at a rising edge with start high and busy low. Write
// pixel and read word each run an issue step, which reads a 32-bit word of
// the single-port store, then a finish step, which writes the merged byte
// back or presents the result; the next command may be taken in the finish
// step, so a new write or read starts before the last one is done. A read
// result is on read_word for exactly one cycle with read_valid high, in the
// finish step; it is not held, so the receiver must take it then. Clear
// sweeps all ceil(ROW_STRIDE*ROWS/4) words (8256 at the defaults) of the
// store one word a cycle with busy high, and the same sweep runs after
// reset before the first command is taken. pixel_format is written over
// the cfg channel, which is always ready; write it only while idle.

module packed_gray_framebuffer #(
    parameter int ROWS          = pgf_pkg::ROWS_DEF,
    parameter int ROW_STRIDE    = pgf_pkg::ROW_STRIDE_DEF,
    parameter int PACKED_STRIDE = pgf_pkg::PACKED_STRIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [pgf_pkg::X_W-1:0]       x_pos,
    input  logic [pgf_pkg::Y_W-1:0]       y_pos,
    input  logic [pgf_pkg::SHADE_W-1:0]   shade,
    input  logic [pgf_pkg::WIDX_W-1:0]    word_index,
    // configuration channel, pixel_format only
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    // result channel, one-cycle strobe
    output logic                          read_valid,
    output logic [pgf_pkg::WORD_W-1:0]    read_word
);

    import pgf_pkg::*;

    pgf_cmd_t    cmd;
    pgf_status_t status;
    action_t     action_code;

    // the cfg register sits in the datapath and takes a write at any time
    assign cfg_ready   = 1'b1;
    assign action_code = action_t'(action);

    // controller: clear sweep, accept, issue (memory read), finish (write back or result)
    pgf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action_code),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath: address math, byte packing, word store, clear counter
    pgf_datapath #(
        .ROWS          (ROWS),
        .ROW_STRIDE    (ROW_STRIDE),
        .PACKED_STRIDE (PACKED_STRIDE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .action     (action_code),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .shade      (shade),
        .word_index (word_index),
        .read_valid (read_valid),
        .read_word  (read_word)
    );

`ifndef SYNTHESIS
    // a memory read is always followed by its write back or result cycle
    a_issue_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> cmd.finish)
        else $error("issue cycle not followed by finish");

    // a result transfer comes only in the cycle after a memory read
    a_result_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid |-> $past(cmd.issue))
        else $error("read result without preceding memory read");

    // no command may be taken while the clear sweep owns the store
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> (busy && !cmd.load))
        else $error("command accepted during clear sweep");
`endif

endmodule

[bench/tb.sv]
// tb: self-checking bench for packed_gray_framebuffer, top module tb
// depends on pgf_pkg and the packed_gray_framebuffer rtl; keeps its own byte image of
// the store to predict every word read back for the panel flush

`timescale 1ns / 1ps

module tb;
    import pgf_pkg::*;

    // geometry of the block as built
    localparam int ROWS          = ROWS_DEF;
    localparam int ROW_STRIDE    = ROW_STRIDE_DEF;
    localparam int PACKED_STRIDE = PACKED_STRIDE_DEF;
    localparam int STORE_BYTES   = ROW_STRIDE * ROWS;
    localparam int LAST_WORD     = STORE_BYTES / 4 - 1;

    // item count, settle time after a drain, run limit
    localparam int ITEM_TARGET   = 550;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1000000;

    // byte image of the framebuffer and the queue of words still owed by the block
    class fb_shadow;
        logic [7:0]  pixel_bytes [STORE_BYTES];
        logic        gray_format;
        logic [31:0] pending_words [$];
        int          mismatches;
        int          words_checked;

        function new();
            gray_format   = FMT_LINEAR;
            mismatches    = 0;
            words_checked = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (pixel_bytes[i])
                pixel_bytes[i] = 8'h00;
        endfunction

        // bytes past the end of the store read as zero
        function logic [7:0] peek(int unsigned addr);
            if (addr < STORE_BYTES)
                return pixel_bytes[addr];
            return 8'h00;
        endfunction

        // apply one accepted command to the image, queue a word for a read
        function void take_command(action_t act, logic [8:0] x, logic [6:0] y,
                                   logic [7:0] s, logic [13:0] w);
            int unsigned xi;
            int unsigned yi;
            int unsigned addr;
            logic [7:0]  b;
            logic [1:0]  v;
            xi = 32'(x);
            yi = 32'(y);
            v  = s[1:0];
            case (act)
                ACT_WRITE:
                begin
                    if (xi < ROW_STRIDE && yi < ROWS)
                    begin
                        if (gray_format == FMT_PACKED)
                        begin
                            addr = xi / 3 + yi * PACKED_STRIDE;
                            if (xi / 3 < PACKED_STRIDE && addr < STORE_BYTES)
                            begin
                                b = pixel_bytes[addr];
                                case (xi % 3)
                                    0:       b = (b & MASK_LANE0) | {v, 6'b0};
                                    1:       b = (b & MASK_LANE1) | {3'b0, v, 3'b0};
                                    default: b = (b & MASK_LANE2) | {6'b0, v};
                                endcase
                                pixel_bytes[addr] = b | FILL_BITS;
                            end
                        end
                        else
                        begin
                            addr = xi + yi * ROW_STRIDE;
                            if (addr < STORE_BYTES)
                                pixel_bytes[addr] = s;
                        end
                    end
                end
                ACT_READ:
                begin
                    addr = 4 * int'(w);
                    pending_words.push_back({peek(addr + 3), peek(addr + 2),
                                             peek(addr + 1), peek(addr)});
                end
                ACT_CLEAR:
                    wipe();
                default:
                    ;
            endcase
        endfunction

        // compare one strobed word with the oldest one owed
        function void match_read(logic [31:0] got);
            logic [31:0] want;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected read_word %h with no read outstanding", got);
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("read_word mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // command side, every input known from time zero
    logic                start      = 1'b0;
    logic [1:0]          action     = ACT_WRITE;
    logic [X_W-1:0]      x_pos      = '0;
    logic [Y_W-1:0]      y_pos      = '0;
    logic [SHADE_W-1:0]  shade      = '0;
    logic [WIDX_W-1:0]   word_index = '0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_data   = FMT_LINEAR;

    // outputs of the block
    logic                busy;
    logic                cfg_ready;
    logic                read_valid;
    logic [WORD_W-1:0]   read_word;

    fb_shadow shadow;

    // run statistics for the closing summary
    int cycle_count   = 0;
    int n_reads       = 0;
    int n_writes      = 0;
    int n_clears      = 0;
    int n_idle_acts   = 0;
    int n_fmt_writes  = 0;
    bit quiet_run     = 1'b0;
    int recent_word   = 0;
    int hot_row       = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    packed_gray_framebuffer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .shade      (shade),
        .word_index (word_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .read_valid (read_valid),
        .read_word  (read_word)
    );

    // the strobe cannot be held off, so every strobed word is taken at the edge ending it
    always @(posedge clk)
    begin
        if (rst_n && read_valid === 1'b1)
            shadow.match_read(read_word);
    end

    // watchdog: covers the post-reset sweep, every clear sweep and the longest gaps
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // sender gap: mostly none or short, a few long, none at all during quiet runs
    function automatic int next_gap();
        int r;
        if (quiet_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // one command transfer; start stays high into the next call when the gap is zero
    task automatic send_command(input action_t act, input logic [8:0] x,
                                input logic [6:0] y, input logic [7:0] s,
                                input logic [13:0] w);
        int gap;
        gap        = next_gap();
        action     <= act;
        x_pos      <= x;
        y_pos      <= y;
        shade      <= s;
        word_index <= w;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // transfer happened at this edge
        shadow.take_command(act, x, y, s, w);
        case (act)
            ACT_WRITE: n_writes++;
            ACT_READ:  n_reads++;
            ACT_CLEAR: n_clears++;
            default:   n_idle_acts++;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every owed word is in and the block has gone idle;
    // a write gives no result, so a few extra cycles cover its write-back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (shadow.pending_words.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel_format register write, only from an idle block
    task automatic write_format(input logic fmt);
        settle();
        cfg_data  <= fmt;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow.gray_format = fmt;
        cfg_valid <= 1'b0;
        n_fmt_writes++;
    endtask

    // one random command; writes cluster on a hot row and reads mostly fetch
    // the word last written, so read-back data is rarely just zero
    task automatic random_command(output bit counted);
        int          r;
        int          a;
        logic [8:0]  x;
        logic [6:0]  y;
        logic [7:0]  s;
        logic [13:0] w;
        r = $urandom_range(0, 999);
        x = 9'($urandom_range(0, ROW_STRIDE - 1));
        y = 7'($urandom_range(0, 127));
        s = 8'($urandom_range(0, 255));
        w = 14'($urandom_range(0, 16383));
        counted = 1'b1;
        if (r < 8)
            send_command(ACT_CLEAR, x, y, s, w);
        else if (r < 30)
        begin
            // unused action code, ignored by the block
            counted = 1'b0;
            send_command(ACT_NONE, 9'($urandom_range(0, 511)), y, s, w);
        end
        else if (r < 520)
        begin
            if ($urandom_range(0, 4) == 0)
                x = 9'($urandom_range(0, 511));
            if ($urandom_range(0, 9) < 7)
                y = 7'(hot_row + int'($urandom_range(0, 1)));
            if (x < ROW_STRIDE)
            begin
                if (shadow.gray_format == FMT_PACKED)
                    a = int'(x) / 3 + int'(y) * PACKED_STRIDE;
                else
                    a = int'(x) + int'(y) * ROW_STRIDE;
                recent_word = a / 4;
            end
            else
                counted = 1'b0;
            send_command(ACT_WRITE, x, y, s, w);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                w = 14'(recent_word);
            else if (r < 90)
                w = 14'($urandom_range(0, LAST_WORD));
            send_command(ACT_READ, x, y, s, w);
        end
    endtask

    initial
    begin
        int  done;
        int  goal;
        bit  counted;
        shadow = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset starts a clearing sweep; wait it out before touching the register
        write_format(FMT_LINEAR);

        // directed, byte-per-pixel format: corners, rejected columns, reads past the store
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'd0);
        send_command(ACT_WRITE, 9'd0,   7'd0,   8'hFF, 14'd0);
        send_command(ACT_WRITE, 9'd257, 7'd127, 8'hA5, 14'd0);
        send_command(ACT_WRITE, 9'd258, 7'd5,   8'h11, 14'd0);
        send_command(ACT_WRITE, 9'd511, 7'd127, 8'h22, 14'd16383);
        send_command(ACT_WRITE, 9'd256, 7'd127, 8'h00, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'(LAST_WORD));
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'(LAST_WORD + 1));
        send_command(ACT_READ,  9'd511, 7'd127, 8'hFF, 14'd16383);
        send_command(ACT_NONE,  9'd511, 7'd127, 8'hFF, 14'd16383);
        send_command(ACT_CLEAR, 9'd0,   7'd0,   8'h00, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'(LAST_WORD));
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'd0);

        // directed, packed format: each lane, last column, rejected column, lane rewrite
        write_format(FMT_PACKED);
        send_command(ACT_WRITE, 9'd0,   7'd0,   8'h03, 14'd0);
        send_command(ACT_WRITE, 9'd1,   7'd0,   8'h02, 14'd0);
        send_command(ACT_WRITE, 9'd2,   7'd0,   8'h01, 14'd0);
        send_command(ACT_WRITE, 9'd257, 7'd127, 8'hFF, 14'd0);
        send_command(ACT_WRITE, 9'd255, 7'd127, 8'hFC, 14'd0);
        send_command(ACT_WRITE, 9'd258, 7'd0,   8'h03, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'((85 + 127 * PACKED_STRIDE) / 4));
        send_command(ACT_WRITE, 9'd1,   7'd0,   8'h00, 14'd0);
        send_command(ACT_READ,  9'd0,   7'd0,   8'h00, 14'd0);

        // random phases, alternating the format; each boundary drains the block first
        done = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_format(p[0] ? FMT_LINEAR : FMT_PACKED);
            quiet_run   = (p == 2 || p == 5);
            hot_row     = $urandom_range(0, 126);
            recent_word = $urandom_range(0, LAST_WORD);
            goal        = (p + 1) * ITEM_TARGET / PHASES;
            while (done < goal)
            begin
                random_command(counted);
                if (counted)
                    done++;
            end
        end

        // final drain, then a few cycles for any stray strobe
        settle();
        repeat (8) @(posedge clk);

        $display("run covered %0d reads, %0d writes, %0d clears, %0d unused-action commands",
                 n_reads, n_writes, n_clears, n_idle_acts);
        $display("%0d format register writes over both formats, %0d words compared, %0d mismatches",
                 n_fmt_writes, shadow.words_checked, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending_words.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
